>>> hdl/msvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msvf_pkg
// Shared constants, register and command codes, and types for the multimode
// state variable filter.
// ----------------------------------------------------------------------------
package msvf_pkg;

	// default datapath sizing
	localparam int SAMPLE_WIDTH_DEF     = 24;
	localparam int STATE_GUARD_BITS_DEF = 8;

	// register file geometry
	localparam int COEF_WIDTH     = 32;
	localparam int DAMP_WIDTH     = 31;
	localparam int MODE_WIDTH     = 3;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = 32;

	// fraction bits of the coefficient formats
	localparam int COEF_FRAC = 31;
	localparam int DAMP_FRAC = 24;

	// register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_A1   = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_A2   = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_A3   = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_DAMP = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MODE = 3'd4;

	// register reset values
	localparam logic [COEF_WIDTH-1:0] A1_RST   = 32'h8000_0000;
	localparam logic [COEF_WIDTH-1:0] A2_RST   = 32'h0;
	localparam logic [COEF_WIDTH-1:0] A3_RST   = 32'h0;
	localparam logic [DAMP_WIDTH-1:0] DAMP_RST = 31'd23726566;
	localparam logic [MODE_WIDTH-1:0] MODE_RST = 3'd0;

	// filter modes
	localparam logic [MODE_WIDTH-1:0] MODE_LOW   = 3'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_BAND  = 3'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_HIGH  = 3'd2;
	localparam logic [MODE_WIDTH-1:0] MODE_NOTCH = 3'd3;
	localparam logic [MODE_WIDTH-1:0] MODE_PEAK  = 3'd4;

	// multiply sequence steps
	localparam logic [2:0] PH_NONE = 3'd0;
	localparam logic [2:0] PH_LOAD = 3'd1;
	localparam logic [2:0] PH_LO   = 3'd2;
	localparam logic [2:0] PH_HI   = 3'd3;
	localparam logic [2:0] PH_SUM  = 3'd4;
	localparam logic [2:0] PH_ACC  = 3'd5;

	// products, in issue order
	localparam logic [2:0] PR_S1A1 = 3'd0;
	localparam logic [2:0] PR_V3A2 = 3'd1;
	localparam logic [2:0] PR_S1A2 = 3'd2;
	localparam logic [2:0] PR_V3A3 = 3'd3;
	localparam logic [2:0] PR_V1K  = 3'd4;

	typedef struct packed {
		logic [COEF_WIDTH-1:0] a1;
		logic [COEF_WIDTH-1:0] a2;
		logic [COEF_WIDTH-1:0] a3;
		logic [DAMP_WIDTH-1:0] damp;
		logic [MODE_WIDTH-1:0] mode;
	} cfg_t;

	typedef struct packed {
		logic       start;   // sample beat accepted
		logic [2:0] phase;   // multiply step
		logic [2:0] prod;    // product in flight
		logic       update;  // integrator and mode result update
		logic       emit;    // load output register
	} cmd_t;

endpackage

>>> hdl/msvf_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msvf_regs
// Coefficient, damping and mode registers behind a plain write port.
// ----------------------------------------------------------------------------
module msvf_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [msvf_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [msvf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	output msvf_pkg::cfg_t                       cfg
);
	import msvf_pkg::*;

	cfg_t cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a1   <= A1_RST;
			cfg_q.a2   <= A2_RST;
			cfg_q.a3   <= A3_RST;
			cfg_q.damp <= DAMP_RST;
			cfg_q.mode <= MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A1:   cfg_q.a1   <= cfg_data[COEF_WIDTH-1:0];
				REG_A2:   cfg_q.a2   <= cfg_data[COEF_WIDTH-1:0];
				REG_A3:   cfg_q.a3   <= cfg_data[COEF_WIDTH-1:0];
				REG_DAMP: cfg_q.damp <= cfg_data[DAMP_WIDTH-1:0];
				REG_MODE: cfg_q.mode <= cfg_data[MODE_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/msvf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msvf_ctrl
// Sequencer: walks the five products through the shared multiplier, then the
// integrator update and the output register handoff.
// ----------------------------------------------------------------------------
module msvf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output msvf_pkg::cmd_t cmd
);
	import msvf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [2:0] ph_q;
	logic [2:0] pr_q;
	logic       out_valid_q;
	logic       accept;
	logic       emit;

	assign accept = (state_q == ST_IDLE) && in_valid;
	// output register is free, or its beat leaves this cycle
	assign emit   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// command word
	always_comb begin
		cmd.start  = accept;
		cmd.phase  = (state_q == ST_MUL) ? ph_q : PH_NONE;
		cmd.prod   = pr_q;
		cmd.update = (state_q == ST_UPD);
		cmd.emit   = emit;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PH_LOAD;
			pr_q    <= PR_S1A1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
						ph_q    <= PH_LOAD;
						pr_q    <= PR_S1A1;
					end
				end
				ST_MUL: begin
					unique case (ph_q)
						PH_LOAD: ph_q <= PH_LO;
						PH_LO:   ph_q <= PH_HI;
						PH_HI:   ph_q <= PH_SUM;
						PH_SUM:  ph_q <= PH_ACC;
						default: begin
							ph_q <= PH_LOAD;
							if (pr_q == PR_V1K) begin
								state_q <= ST_UPD;
							end else begin
								pr_q <= pr_q + 3'd1;
							end
						end
					endcase
				end
				ST_UPD: state_q <= ST_DONE;
				default: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> hdl/msvf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msvf_dp
// Filter datapath: integrator states, shared half-width multiplier with
// round-to-nearest accumulate, integrator saturation and mode output.
// ----------------------------------------------------------------------------
module msvf_dp #(
	parameter int SAMPLE_WIDTH     = msvf_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_GUARD_BITS = msvf_pkg::STATE_GUARD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  msvf_pkg::cfg_t                 cfg,
	input  msvf_pkg::cmd_t                 cmd,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);
	import msvf_pkg::*;

	localparam int STW = SAMPLE_WIDTH + STATE_GUARD_BITS; // integrator width
	localparam int VW  = STW + 3;                         // v1, v2 operand width
	localparam int CW  = (VW + 1) / 2;                    // multiplier chunk width
	localparam int PW  = CW + COEF_WIDTH;                 // chunk product width
	localparam int FW  = 2 * CW + COEF_WIDTH + 1;         // full product plus round
	localparam int RW  = VW + 7;                          // accumulator width (k < 128)
	localparam int TW  = RW + 2;                          // update and mode width

	localparam logic signed [TW-1:0] I_MAX = {{(TW - STW + 1){1'b0}}, {(STW - 1){1'b1}}};
	localparam logic signed [TW-1:0] I_MIN = ~I_MAX;
	localparam logic signed [TW-1:0] O_MAX =
		{{(TW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [TW-1:0] O_MIN = ~O_MAX;

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [STW-1:0]          s1_q;
	logic signed [STW-1:0]          s2_q;
	logic signed [STW:0]            v3_q;
	logic signed [RW-1:0]           v1_q;
	logic signed [RW-1:0]           v2_q;
	logic signed [RW-1:0]           kv_q;
	logic [2*CW-1:0]                mag_q;
	logic                           neg_q;
	logic [COEF_WIDTH-1:0]          coef_q;
	logic [PW-1:0]                  prod_q;
	logic [FW-1:0]                  full_q;
	logic signed [TW-1:0]           y_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;

	logic [VW-1:0]         op;
	logic [COEF_WIDTH-1:0] coef;
	logic                  is_damp;
	logic [VW-1:0]         mag_c;
	logic [CW-1:0]         chunk;
	logic [PW-1:0]         prod_c;
	logic [FW-1:0]         half;
	logic [FW-1:0]         shr;
	logic [RW-1:0]         rmag;
	logic signed [RW-1:0]  addend;
	logic signed [TW-1:0]  t1;
	logic signed [TW-1:0]  t2;
	logic signed [TW-1:0]  i1_sat;
	logic signed [TW-1:0]  i2_sat;
	logic signed [TW-1:0]  xe;
	logic signed [TW-1:0]  kve;
	logic signed [TW-1:0]  v1e;
	logic signed [TW-1:0]  v2e;
	logic signed [TW-1:0]  y_c;
	logic signed [TW-1:0]  o_sat;

	// operand and coefficient for the product in flight
	always_comb begin
		unique case (cmd.prod)
			PR_S1A1: begin
				op   = VW'(s1_q);
				coef = cfg.a1;
			end
			PR_V3A2: begin
				op   = VW'(v3_q);
				coef = cfg.a2;
			end
			PR_S1A2: begin
				op   = VW'(s1_q);
				coef = cfg.a2;
			end
			PR_V3A3: begin
				op   = VW'(v3_q);
				coef = cfg.a3;
			end
			PR_V1K: begin
				op   = v1_q[VW-1:0];
				coef = COEF_WIDTH'(cfg.damp);
			end
			default: begin
				op   = '0;
				coef = '0;
			end
		endcase
	end

	assign is_damp = (cmd.prod == PR_V1K);
	assign mag_c   = op[VW-1] ? (~op + 1'b1) : op;

	// one chunk of the magnitude times the coefficient
	assign chunk  = (cmd.phase == PH_LO) ? mag_q[CW-1:0] : mag_q[2*CW-1:CW];
	assign prod_c = PW'(chunk) * PW'(coef_q);

	// round half up on the magnitude, then restore the sign
	assign half   = is_damp ? (FW'(1) << (DAMP_FRAC - 1)) : (FW'(1) << (COEF_FRAC - 1));
	assign shr    = is_damp ? (full_q >> DAMP_FRAC) : (full_q >> COEF_FRAC);
	assign rmag   = shr[RW-1:0];
	assign addend = (rmag ^ {RW{neg_q}}) + RW'(neg_q);

	// trapezoidal state update with saturation
	assign t1     = (TW'(v1_q) <<< 1) - TW'(s1_q);
	assign t2     = (TW'(v2_q) <<< 1) - TW'(s2_q);
	assign i1_sat = (t1 > I_MAX) ? I_MAX : ((t1 < I_MIN) ? I_MIN : t1);
	assign i2_sat = (t2 > I_MAX) ? I_MAX : ((t2 < I_MIN) ? I_MIN : t2);

	// mode mix
	assign xe  = TW'(x_q);
	assign kve = TW'(kv_q);
	assign v1e = TW'(v1_q);
	assign v2e = TW'(v2_q);

	always_comb begin
		unique case (cfg.mode)
			MODE_LOW:   y_c = v2e;
			MODE_BAND:  y_c = v1e;
			MODE_HIGH:  y_c = xe - kve - v2e;
			MODE_NOTCH: y_c = xe - kve;
			MODE_PEAK:  y_c = xe - kve - (v2e <<< 1);
			default:    y_c = '0;
		endcase
	end

	assign o_sat = (y_q > O_MAX) ? O_MAX : ((y_q < O_MIN) ? O_MIN : y_q);

	// integrator states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
			s2_q <= '0;
		end else if (cmd.update) begin
			s1_q <= i1_sat[STW-1:0];
			s2_q <= i2_sat[STW-1:0];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q  <= sample_in;
			v3_q <= (STW + 1)'(sample_in) - (STW + 1)'(s2_q);
			v1_q <= '0;
			v2_q <= RW'(s2_q);
			kv_q <= '0;
		end
		unique case (cmd.phase)
			PH_LOAD: begin
				mag_q  <= (2 * CW)'(mag_c);
				neg_q  <= op[VW-1];
				coef_q <= coef;
			end
			PH_LO: prod_q <= prod_c;
			PH_HI: begin
				full_q <= FW'(prod_q) + half;
				prod_q <= prod_c;
			end
			PH_SUM: full_q <= full_q + (FW'(prod_q) << CW);
			PH_ACC: begin
				unique case (cmd.prod)
					PR_S1A1, PR_V3A2: v1_q <= v1_q + addend;
					PR_S1A2, PR_V3A3: v2_q <= v2_q + addend;
					default:          kv_q <= kv_q + addend;
				endcase
			end
			default: begin
			end
		endcase
		if (cmd.update) begin
			y_q <= y_c;
		end
		if (cmd.emit) begin
			out_q <= o_sat[SAMPLE_WIDTH-1:0];
		end
	end

	assign sample_out = out_q;

endmodule

>>> hdl/multimode_state_variable_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multimode_state_variable_filter
// Trapezoidal two-integrator state variable filter with lowpass, bandpass,
// highpass, notch and peak outputs, fixed-point coefficients from software.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   config   | cfg_we               | cfg_index, cfg_data
//   input    | in_valid / in_stall  | sample_in  (signed Q1.23)
//   output   | out_valid / out_stall| sample_out (signed Q1.23, sat.)
//
// Each sample runs through the accept beat, five products of five steps
// each on one shared multiplier (operand split into two halves), one state
// update step and one step into the output register.
// Reset clears both integrators and loads the default coefficients.
// A waiting result sits in the output register; the next sample is worked
// out meanwhile and holds in its last step until that beat is taken.
// ----------------------------------------------------------------------------
module multimode_state_variable_filter #(
	parameter int SAMPLE_WIDTH     = msvf_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_GUARD_BITS = msvf_pkg::STATE_GUARD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [msvf_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [msvf_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
	import msvf_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	// configuration registers
	msvf_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	msvf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath
	msvf_dp #(
		.SAMPLE_WIDTH     (SAMPLE_WIDTH),
		.STATE_GUARD_BITS (STATE_GUARD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule
